/* hw/rtl/sdspi_pkg.sv */
package sdspi_pkg;

  localparam int MaxBlockBytes = 512;
  localparam int MaxRespBytes  = 5;
  localparam int BlkCntW       = $clog2(MaxBlockBytes + 1);
  localparam int RespIdxW      = $clog2(MaxRespBytes);
  localparam int RespCntW      = $clog2(MaxRespBytes + 1);

  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_BYTE = 2'd3;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_ILLEGAL  = 4'd1;
  localparam logic [3:0] ST_TIMEOUT  = 4'd2;
  localparam logic [3:0] ST_R1ERR    = 4'd3;
  localparam logic [3:0] ST_WRONG    = 4'd4;
  localparam logic [3:0] ST_VOLTAGE  = 4'd5;
  localparam logic [3:0] ST_CAPACITY = 4'd6;
  localparam logic [3:0] ST_INACTIVE = 4'd7;
  localparam logic [3:0] ST_TOKEN    = 4'd8;

  localparam logic [1:0] REG_BLOCK_LEN = 2'd0;
  localparam logic [1:0] REG_POLL_LIM  = 2'd1;
  localparam logic [1:0] REG_RETRY_LIM = 2'd2;
  localparam logic [1:0] REG_PRECLOCK  = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE, PH_PRE, PH_FRAME, PH_POLL, PH_RESP, PH_TAIL,
    PH_BPOLL, PH_TOKEN, PH_DATA, PH_BTAIL
  } phase_t;

  typedef enum logic [1:0] {KIND_CMD, KIND_INIT, KIND_READ} kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  command_index;
    logic [31:0] command_argument;
    logic [2:0]  response_length;
    logic [7:0]  rx_byte;
  } in_req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select_n;
    logic       data_valid;
    logic       data_kind;
    logic [7:0] data_byte;
    logic       done_res;
    logic [3:0] status;
    logic [7:0] error_code_byte;
    logic       high_capacity_card;
  } out_req_t;

  // classified request handed from front to engine
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  idx;
    logic [31:0] arg;
    logic [RespCntW-1:0] len;
    logic [7:0]  rx;
  } cls_req_t;

endpackage

/* hw/rtl/sd_spi_init_and_block_read_unit.sv */
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_stall   | in_data  (sdspi_pkg::in_req_t)
// out_    | output    | out_valid/out_stall | out_data (sdspi_pkg::out_req_t)
// cfg_    | input     | APB psel/penable    | pwdata/prdata, four registers
//
// Each request gives exactly one result. An accepted request is written into
// the front queue, popped by the engine when its output register can move,
// and its result is registered there; the engine takes one request a cycle
// while its output register can move. The front queue holds two requests and
// stalls the input only when full. rst_n is synchronous, active low: engine
// idle, chip select high, registers at their defaults. out_stall holds the
// result register and backs up the queue.
module sd_spi_init_and_block_read_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdspi_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sdspi_pkg::out_req_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import sdspi_pkg::*;

  logic [9:0] blk_len_r;
  logic [7:0] poll_lim_r, retry_lim_r;
  logic [4:0] preclk_r;
  logic       q_valid, q_pop, cfg_wr;
  cls_req_t   q_data;
  logic [1:0] ra;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign ra = cfg_paddr[3:2];

  // register write: ignore the unaligned low address bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_len_r <= 10'd512; poll_lim_r <= 8'd100; retry_lim_r <= 8'd100; preclk_r <= 5'd10;
    end else if (cfg_wr) begin
      case (ra)
        REG_BLOCK_LEN: blk_len_r   <= cfg_pwdata[9:0];
        REG_POLL_LIM:  poll_lim_r  <= cfg_pwdata[7:0];
        REG_RETRY_LIM: retry_lim_r <= cfg_pwdata[7:0];
        default:       preclk_r    <= cfg_pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    case (ra)
      REG_BLOCK_LEN: cfg_prdata = {22'd0, blk_len_r};
      REG_POLL_LIM:  cfg_prdata = {24'd0, poll_lim_r};
      REG_RETRY_LIM: cfg_prdata = {24'd0, retry_lim_r};
      default:       cfg_prdata = {27'd0, preclk_r};
    endcase
  end

  sdspi_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_pop, .q_data
  );

  sdspi_engine u_engine (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .block_length(blk_len_r), .poll_limit(poll_lim_r),
    .init_retry_limit(retry_lim_r), .preclock_bytes(preclk_r),
    .out_valid, .out_stall, .out_data
  );
endmodule

/* hw/rtl/sdspi_front.sv */
module sdspi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdspi_pkg::in_req_t  in_data,
  output logic                q_valid,
  input  logic                q_pop,
  output sdspi_pkg::cls_req_t q_data
);
  import sdspi_pkg::*;

  // two-entry queue; the engine checks opcode against its own phase on pop
  cls_req_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cls_req_t   c;
  logic       push;
  logic [2:0] ln;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  // clamp the response length into 1..MaxRespBytes
  always_comb begin
    ln = (in_data.response_length == 3'd0) ? 3'd1 :
         (in_data.response_length > 3'(MaxRespBytes)) ? 3'(MaxRespBytes)
                                                       : in_data.response_length;
    c.opcode = in_data.opcode;
    c.idx    = in_data.command_index;
    c.arg    = in_data.command_argument;
    c.len    = RespCntW'(ln);
    c.rx     = in_data.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) mem_r[wp_r] <= c;
  end
endmodule

/* hw/rtl/sdspi_engine.sv */
module sdspi_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  sdspi_pkg::cls_req_t q_data,
  input  logic [9:0]          block_length,
  input  logic [7:0]          poll_limit,
  input  logic [7:0]          init_retry_limit,
  input  logic [4:0]          preclock_bytes,
  output logic                out_valid,
  input  logic                out_stall,
  output sdspi_pkg::out_req_t out_data
);
  import sdspi_pkg::*;

  phase_t      phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic [BlkCntW-1:0] bc_r, bc_nxt;
  logic [7:0]  pc_r, pc_nxt, rc_r, rc_nxt;
  logic [7:0]  rs_r [MaxRespBytes];
  logic [31:0] arg_r, arg_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        v2_r, v2_nxt, cs_r, cs_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [RespCntW-1:0] rl_r, rl_nxt;
  logic        rs_we;
  logic [RespIdxW-1:0] rs_wa;
  out_req_t    o, ob_r;
  logic        ov_r;
  logic        fire;
  logic        wrong;
  logic [7:0]  rx, plim, rlim, ilim;
  logic [4:0]  plk;
  logic [BlkCntW-1:0] blen;

  assign fire  = q_valid && (!ov_r || !out_stall);
  assign q_pop = fire;
  assign out_valid = ov_r;
  assign out_data  = ob_r;
  assign rx = q_data.rx;
  // a received byte needs a busy engine, a start needs an idle one
  assign wrong = (q_data.opcode == OP_BYTE) != (phase_r != PH_IDLE);

  function automatic logic [7:0] crc_of(input logic [7:0] i);
    crc_of = (i == 8'd8) ? 8'h87 : (i == 8'd0) ? 8'h95 : 8'h01;
  endfunction

  always_comb begin
    logic [7:0] ci;
    logic [31:0] ca;
    logic [RespCntW-1:0] cl;
    logic       go;
    logic [7:0] r1;
    logic [BlkCntW-1:0] bcp;
    ci = 8'd0; ca = 32'd0; cl = '0; go = 1'b0; r1 = rs_r[0];
    bcp = bc_r + 1'b1;
    plim = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
    ilim = (init_retry_limit == 8'd0) ? 8'd1 : init_retry_limit;
    plk  = (preclock_bytes == 5'd0) ? 5'd1 : preclock_bytes;
    blen = (block_length == 10'd0) ? BlkCntW'(1) :
           ({1'b0, block_length} > 11'(MaxBlockBytes)) ? BlkCntW'(MaxBlockBytes)
                                                        : BlkCntW'(block_length);
    rlim = 8'd0;
    phase_nxt = phase_r; kind_nxt = kind_r; bc_nxt = bc_r; pc_nxt = pc_r;
    rc_nxt = rc_r; arg_nxt = arg_r; crc_nxt = crc_r; v2_nxt = v2_r;
    cs_nxt = cs_r; step_nxt = step_r; rl_nxt = rl_r;
    rs_we = 1'b0; rs_wa = '0;
    o = '0;
    if (wrong) begin
      o.done_res = 1'b1; o.status = ST_WRONG;
    end else begin
      case (q_data.opcode)
        OP_INIT: begin
          kind_nxt = KIND_INIT; cs_nxt = 1'b1; v2_nxt = 1'b0; rc_nxt = 8'd0;
          bc_nxt = BlkCntW'(1); phase_nxt = PH_PRE; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
        end
        OP_CMD: begin
          kind_nxt = KIND_CMD;
          if (q_data.idx > 8'd63) begin
            phase_nxt = PH_IDLE; o.done_res = 1'b1; o.status = ST_ILLEGAL;
          end else begin
            go = 1'b1; ci = q_data.idx; ca = q_data.arg; cl = q_data.len;
          end
        end
        OP_READ: begin
          kind_nxt = KIND_READ; cs_nxt = 1'b0; pc_nxt = 8'd1; phase_nxt = PH_BPOLL;
          o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
        end
        default: begin
          case (phase_r)
            PH_PRE: begin
              if (bc_r >= BlkCntW'(plk)) begin
                go = 1'b1; step_nxt = 3'd0; cl = RespCntW'(1);
              end else begin
                bc_nxt = bcp; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
              end
            end
            PH_FRAME: begin
              o.tx_valid = 1'b1;
              if (bc_r < BlkCntW'(5)) begin
                o.tx_byte = arg_r[31:24]; arg_nxt = {arg_r[23:0], 8'h00}; bc_nxt = bcp;
              end else if (bc_r == BlkCntW'(5)) begin
                o.tx_byte = crc_r; bc_nxt = BlkCntW'(6);
              end else begin
                pc_nxt = 8'd1; phase_nxt = PH_POLL; o.tx_byte = 8'hFF;
              end
            end
            PH_POLL, PH_BPOLL, PH_TOKEN: begin
              if (rx == 8'hFF) begin
                if (pc_r >= plim) begin
                  o.done_res = 1'b1; o.status = ST_TIMEOUT; phase_nxt = PH_IDLE;
                end else begin
                  pc_nxt = pc_r + 8'd1; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
                end
              end else if (phase_r == PH_POLL) begin
                rs_we = 1'b1;
                o.data_valid = 1'b1; o.data_byte = rx;
                if (kind_r == KIND_INIT && step_r == 3'd1 && rx == 8'h05) begin
                  v2_nxt = 1'b0; go = 1'b1; step_nxt = 3'd2;
                  ci = 8'd58; cl = RespCntW'(5);
                end else if (rx != 8'h00 && rx != 8'h01) begin
                  o.done_res = 1'b1; o.status = ST_R1ERR; o.error_code_byte = rx;
                  phase_nxt = PH_IDLE;
                end else begin
                  bc_nxt = BlkCntW'(1);
                  phase_nxt = (rl_r > RespCntW'(1)) ? PH_RESP : PH_TAIL;
                  o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
                end
              end else if (phase_r == PH_BPOLL) begin
                o.data_valid = 1'b1; o.data_byte = rx;
                if (rx != 8'h00) begin
                  o.done_res = 1'b1; o.status = ST_INACTIVE; phase_nxt = PH_IDLE;
                end else begin
                  pc_nxt = 8'd1; phase_nxt = PH_TOKEN; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
                end
              end else begin
                if (rx != 8'hFE) begin
                  o.done_res = 1'b1; o.status = ST_TOKEN; o.error_code_byte = rx;
                  phase_nxt = PH_IDLE;
                end else begin
                  bc_nxt = '0; phase_nxt = PH_DATA; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
                end
              end
            end
            PH_RESP: begin
              rs_we = 1'b1; rs_wa = RespIdxW'(bc_r);
              o.data_valid = 1'b1; o.data_byte = rx;
              bc_nxt = bcp;
              if (bcp >= BlkCntW'(rl_r)) phase_nxt = PH_TAIL;
              o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
            end
            PH_TAIL: begin
              if (kind_r != KIND_INIT) begin
                o.done_res = 1'b1; phase_nxt = PH_IDLE;
              end else begin
                case (step_r)
                  3'd0: if (r1 != 8'h01) begin
                    o.done_res = 1'b1; o.status = ST_R1ERR; o.error_code_byte = r1;
                  end else begin
                    go = 1'b1; step_nxt = 3'd1; ci = 8'd8; ca = 32'h000001AA;
                    cl = RespCntW'(5);
                  end
                  3'd1: if (r1 != 8'h01) begin
                    o.done_res = 1'b1; o.status = ST_R1ERR; o.error_code_byte = r1;
                  end else if (rs_r[3] != 8'h01) begin
                    o.done_res = 1'b1; o.status = ST_VOLTAGE;
                  end else begin
                    v2_nxt = 1'b1; go = 1'b1; step_nxt = 3'd2; ci = 8'd58;
                    cl = RespCntW'(5);
                  end
                  3'd2: if (r1 != 8'h01) begin
                    o.done_res = 1'b1; o.status = ST_R1ERR; o.error_code_byte = r1;
                  end else if ((rs_r[2] & 8'h30) != 8'h30) begin
                    o.done_res = 1'b1; o.status = ST_VOLTAGE;
                  end else begin
                    rc_nxt = 8'd0; go = 1'b1; step_nxt = 3'd3; ci = 8'd55;
                    cl = RespCntW'(1);
                  end
                  3'd3: begin
                    go = 1'b1; step_nxt = 3'd4; ci = 8'd41; cl = RespCntW'(1);
                    ca = v2_r ? 32'h40000000 : 32'd0;
                  end
                  3'd4: begin
                    rlim = (rc_r < 8'd255) ? rc_r + 8'd1 : rc_r;
                    rc_nxt = rlim;
                    if (r1 == 8'h00) begin
                      go = 1'b1; step_nxt = 3'd5; ci = 8'd58; cl = RespCntW'(5);
                    end else if (rlim >= ilim) begin
                      o.done_res = 1'b1; o.status = ST_TIMEOUT;
                    end else begin
                      go = 1'b1; step_nxt = 3'd3; ci = 8'd55; cl = RespCntW'(1);
                    end
                  end
                  default: if (r1 != 8'h00) begin
                    o.done_res = 1'b1; o.status = ST_R1ERR; o.error_code_byte = r1;
                  end else if ((rs_r[1] & 8'hC0) != 8'hC0) begin
                    o.done_res = 1'b1; o.status = ST_CAPACITY;
                  end else begin
                    o.done_res = 1'b1;
                  end
                endcase
                if (!go) phase_nxt = PH_IDLE;
              end
            end
            PH_DATA: begin
              o.data_valid = 1'b1; o.data_kind = 1'b1; o.data_byte = rx;
              o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
              if (bcp >= blen) begin
                bc_nxt = '0; phase_nxt = PH_BTAIL;
              end else begin
                bc_nxt = bcp;
              end
            end
            PH_BTAIL: begin
              bc_nxt = bcp;
              if (bcp >= BlkCntW'(3)) begin
                o.done_res = 1'b1; phase_nxt = PH_IDLE;
              end else begin
                o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
              end
            end
            default: ;
          endcase
        end
      endcase
      if (go) begin
        arg_nxt = ca; crc_nxt = crc_of(ci); rl_nxt = cl; bc_nxt = BlkCntW'(1);
        phase_nxt = PH_FRAME; cs_nxt = 1'b0;
        o.tx_valid = 1'b1; o.tx_byte = 8'h40 | ci;
      end
      // init and block read always release chip select when they end
      if (o.done_res && kind_nxt != KIND_CMD) cs_nxt = 1'b1;
    end
    o.chip_select_n = cs_nxt;
    o.high_capacity_card = v2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; kind_r <= KIND_CMD; bc_r <= '0; pc_r <= 8'd0; rc_r <= 8'd0;
      arg_r <= 32'd0; crc_r <= 8'h01; v2_r <= 1'b0; cs_r <= 1'b1; step_r <= 3'd0;
      rl_r <= RespCntW'(1); ov_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt; kind_r <= kind_nxt; bc_r <= bc_nxt; pc_r <= pc_nxt;
        rc_r <= rc_nxt; arg_r <= arg_nxt; crc_r <= crc_nxt; v2_r <= v2_nxt;
        cs_r <= cs_nxt; step_r <= step_nxt; rl_r <= rl_nxt;
      end
      if (fire) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
    if (fire) ob_r <= o;
    if (fire && rs_we) rs_r[rs_wa] <= rx;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && o.done_res && !wrong |=> phase_r == PH_IDLE) else $error("done not idle");
  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_valid |-> out_data.tx_byte == 8'h00) else $error("tx byte");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |-> out_data.status == ST_OK) else $error("status");
endmodule
